>>> rtl/abad_pkg.sv
// ----------------------------------------------------------------------------
// abad_pkg: shared types and constants of the adaptive binary arithmetic decoder
// Beat payloads, sizing constants and the probability table.
// ----------------------------------------------------------------------------
package abad_pkg;

  localparam int MAX_CHANNELS = 6;
  localparam int FRAME_BYTES  = 4704;
  localparam int TAPS         = 16;
  localparam int DECODE_BUDGET = 129;

  localparam int CH_W     = 3;
  localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TCNT_W   = $clog2(TAPS + 1);
  localparam int ADDR_W   = $clog2(MAX_CHANNELS * TAPS);
  localparam int PRED_W   = $clog2(TAPS * 128) + 2;
  localparam int BUDGET_W = $clog2(DECODE_BUDGET + 1);
  localparam int BPOS_W   = 13;

  // history encoding: zero, plus one, minus one
  localparam logic [1:0] HIST_ZERO = 2'b00;
  localparam logic [1:0] HIST_POS  = 2'b01;
  localparam logic [1:0] HIST_NEG  = 2'b11;

  typedef struct packed {
    logic stream_bit;
    logic frame_start;
    logic clear_filters;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]      decoded_byte;
    logic [CH_W-1:0] channel;
    logic            last_in_frame;
  } out_beat_t;

  localparam logic [7:0] PROB_ROM [128] = '{
    8'd128, 8'd123, 8'd118, 8'd114, 8'd109, 8'd105, 8'd101, 8'd97,
    8'd93,  8'd90,  8'd86,  8'd83,  8'd80,  8'd77,  8'd74,  8'd71,
    8'd68,  8'd65,  8'd63,  8'd60,  8'd58,  8'd56,  8'd54,  8'd52,
    8'd50,  8'd48,  8'd46,  8'd44,  8'd42,  8'd41,  8'd39,  8'd38,
    8'd36,  8'd35,  8'd33,  8'd32,  8'd31,  8'd30,  8'd29,  8'd27,
    8'd26,  8'd25,  8'd24,  8'd23,  8'd22,  8'd22,  8'd21,  8'd20,
    8'd19,  8'd18,  8'd18,  8'd17,  8'd16,  8'd16,  8'd15,  8'd14,
    8'd14,  8'd13,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,  8'd10,
    8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,   8'd7,
    8'd7,   8'd7,   8'd6,   8'd6,   8'd6,   8'd6,   8'd5,   8'd5,
    8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1
  };

endpackage

>>> rtl/adaptive_binary_arithmetic_decoder.sv
// ----------------------------------------------------------------------------
// adaptive_binary_arithmetic_decoder: bit-serial adaptive arithmetic decoder
// Decodes interleaved channel bytes from a compressed bit stream.
// ----------------------------------------------------------------------------
// Each input beat carries one compressed bit. A beat with frame_start restarts
// the coder (8 code bits load, range 256) and the byte and channel counters;
// clear_filters on that beat also zeroes every channel's weights and history.
// The block takes one input beat, then drops in_ready and works it off with a
// small sequencer around one 9x9 multiplier: it uses the bit if the coder
// needs one (code load or renormalization) and then decodes as many bits as
// it can without input, at most 129. Each decoded bit passes a check step, a
// read pass that reads the channel's 16 weights and history signs from
// on-chip memory and accumulates the prediction, a step that looks up the
// probability and multiplies, a compare step, and a write pass that writes
// adapted weights and the shifted history back; every eighth bit adds an emit
// step. A beat whose bit only loads the coder passes only the idle and check
// states. Every eighth bit yields an output beat; the output register holds
// it and the sequencer stalls only if the previous byte is still not taken.
// channel_count is written on the cfg port while idle; 0 acts as 1 and values
// above 6 act as 6. Weights reset to zero by per-channel valid bits, so there
// is no clearing pass after reset.
module adaptive_binary_arithmetic_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  abad_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output abad_pkg::out_beat_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_data
);
  import abad_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_RD    = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;

  // coder and framing state
  logic [2:0]          channel_count;
  logic [7:0]          code_value;
  logic [8:0]          range_value;
  logic [3:0]          load_count;
  logic                renorm_pending;
  logic [7:0]          byte_accum;
  logic [2:0]          bit_pos;
  logic [CH_W-1:0]     chan_pos;
  logic [BPOS_W-1:0]   byte_pos;
  logic                frame_idle;
  logic                have_bit;
  logic                cur_bit;
  logic [BUDGET_W-1:0] budget;
  logic [MAX_CHANNELS-1:0] row_valid;

  // per-bit working registers
  logic [CH_W-1:0]         cur_ch;
  logic [TCNT_W-1:0]       tcnt;
  logic [TAP_W-1:0]        rd_tap;
  logic                    rd_live;
  logic signed [PRED_W-1:0] pred;
  logic [17:0]             prod;
  logic [8:0]              a_reg;
  logic                    dec_bit;
  logic [1:0]              prev_h;
  logic [7:0]              wbuf [TAPS];
  logic [1:0]              hbuf [TAPS];

  // channel memories
  logic [7:0] weight_mem [MAX_CHANNELS*TAPS];
  logic [1:0] hist_mem   [MAX_CHANNELS*TAPS];
  logic [7:0] w_q;
  logic [1:0] h_q;
  logic              mem_rd, mem_wr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [7:0]        wr_w;
  logic [1:0]        wr_h;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);

  // address of one tap of the current channel
  function automatic logic [ADDR_W-1:0] tap_addr(input logic [CH_W-1:0] ch,
                                                  input logic [TAP_W-1:0] k);
    logic [ADDR_W+CH_W-1:0] full;
    full = (ADDR_W+CH_W)'(ch) * (ADDR_W+CH_W)'(TAPS) + (ADDR_W+CH_W)'(k);
    return full[ADDR_W-1:0];
  endfunction

  // prediction to probability, then the interval split product
  logic [PRED_W-1:0] pred_abs;
  logic [PRED_W-4:0] mag_full;
  logic [6:0]        mag;
  logic [8:0]        prob;
  logic [8:0]        a_val;
  always_comb begin
    pred_abs = pred[PRED_W-1] ? PRED_W'(-pred) : PRED_W'(pred);
    mag_full = pred_abs[PRED_W-1:3];
    mag      = (mag_full > (PRED_W-3)'(127)) ? 7'd127 : mag_full[6:0];
    prob     = pred[PRED_W-1] ? 9'(9'd256 - {1'b0, PROB_ROM[mag]})
                              : {1'b0, PROB_ROM[mag]};
    a_val    = 9'(range_value - 9'd1);
  end

  // compare stage
  logic [17:0] t_full;
  logic [8:0]  t_val;
  logic        take_one;
  always_comb begin
    t_full   = 18'(prod + 18'd128);
    t_val    = t_full[16:8];
    take_one = {1'b0, code_value} > t_val;
  end

  // weight adaptation of the tap on the write pass
  logic [TAP_W-1:0]  wk;
  logic [7:0]        w_old;
  logic [1:0]        h_old;
  logic              err_nz;
  logic signed [8:0] w_sum;
  logic [7:0]        w_new;
  always_comb begin
    wk     = tcnt[TAP_W-1:0];
    w_old  = wbuf[wk];
    h_old  = hbuf[wk];
    err_nz = (dec_bit == pred[PRED_W-1]);
    // step toward the sign that would have predicted the bit
    if ((h_old == HIST_POS) == dec_bit)
      w_sum = $signed({w_old[7], w_old}) + 9'sd1;
    else
      w_sum = $signed({w_old[7], w_old}) - 9'sd1;
    if (!err_nz || h_old == HIST_ZERO)
      w_new = w_old;
    else if (w_sum > 9'sd127)
      w_new = 8'd127;
    else if (w_sum < -9'sd128)
      w_new = 8'h80;
    else
      w_new = w_sum[7:0];
  end

  // byte end bookkeeping
  logic [2:0] active_cnt;
  logic       chan_wrap, last_byte;
  always_comb begin
    if (channel_count == 3'd0)
      active_cnt = 3'd1;
    else if (channel_count > 3'(MAX_CHANNELS))
      active_cnt = 3'(MAX_CHANNELS);
    else
      active_cnt = channel_count;
    chan_wrap = (4'(cur_ch) + 4'd1) >= 4'(active_cnt);
    last_byte = chan_wrap && (byte_pos >= BPOS_W'(FRAME_BYTES - 1));
  end

  // memory ports
  always_comb begin
    mem_rd  = (state == S_RD) && (tcnt < TCNT_W'(TAPS));
    rd_addr = tap_addr(cur_ch, tcnt[TAP_W-1:0]);
    mem_wr  = (state == S_WR);
    wr_addr = tap_addr(cur_ch, wk);
    wr_w    = w_new;
    wr_h    = (wk == '0) ? (dec_bit ? HIST_POS : HIST_NEG) : prev_h;
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      w_q <= weight_mem[rd_addr];
      h_q <= hist_mem[rd_addr];
    end
    if (mem_wr) begin
      weight_mem[wr_addr] <= wr_w;
      hist_mem[wr_addr]   <= wr_h;
    end
  end

  // a never-written row reads as zero
  logic [7:0] w_eff;
  logic [1:0] h_eff;
  assign w_eff = row_valid[cur_ch] ? w_q : 8'd0;
  assign h_eff = row_valid[cur_ch] ? h_q : HIST_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      channel_count  <= 3'd2;
      code_value     <= '0;
      range_value    <= 9'd256;
      load_count     <= '0;
      renorm_pending <= 1'b0;
      byte_accum     <= '0;
      bit_pos        <= '0;
      chan_pos       <= '0;
      byte_pos       <= '0;
      frame_idle     <= 1'b1;
      have_bit       <= 1'b0;
      budget         <= '0;
      row_valid      <= '0;
      out_valid      <= 1'b0;
      rd_live        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        channel_count <= cfg_data;
      // drop the taken byte unless the emit step reloads the register now
      if (out_valid && out_ready && state != S_EMIT)
        out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_bit  <= in_data.stream_bit;
            have_bit <= 1'b1;
            budget   <= BUDGET_W'(DECODE_BUDGET);
            if (in_data.frame_start) begin
              if (in_data.clear_filters)
                row_valid <= '0;
              code_value     <= '0;
              range_value    <= 9'd256;
              load_count     <= '0;
              renorm_pending <= 1'b0;
              byte_accum     <= '0;
              bit_pos        <= '0;
              chan_pos       <= '0;
              byte_pos       <= '0;
              frame_idle     <= 1'b0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (frame_idle) begin
            state <= S_IDLE;
          end else if (load_count < 4'd8) begin
            if (!have_bit) begin
              state <= S_IDLE;
            end else begin
              code_value <= {code_value[6:0], cur_bit};
              load_count <= 4'(load_count + 4'd1);
              have_bit   <= 1'b0;
            end
          end else if (renorm_pending) begin
            if (!have_bit) begin
              state <= S_IDLE;
            end else begin
              range_value <= {range_value[7:0], 1'b0};
              code_value  <= {code_value[6:0], cur_bit};
              have_bit    <= 1'b0;
              if (range_value[7:6] != 2'b00)
                renorm_pending <= 1'b0;
            end
          end else if (budget == '0) begin
            state <= S_IDLE;
          end else begin
            budget <= BUDGET_W'(budget - 1'b1);
            cur_ch <= (chan_pos < CH_W'(MAX_CHANNELS)) ? chan_pos : '0;
            tcnt   <= '0;
            pred   <= '0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          // issue one read per cycle, fold in the tap read the cycle before
          rd_live <= (tcnt < TCNT_W'(TAPS));
          rd_tap  <= tcnt[TAP_W-1:0];
          if (rd_live) begin
            wbuf[rd_tap] <= w_eff;
            hbuf[rd_tap] <= h_eff;
            if (h_eff == HIST_POS)
              pred <= PRED_W'(pred + $signed({{(PRED_W-8){w_eff[7]}}, w_eff}));
            else if (h_eff == HIST_NEG)
              pred <= PRED_W'(pred - $signed({{(PRED_W-8){w_eff[7]}}, w_eff}));
          end
          if (tcnt == TCNT_W'(TAPS)) begin
            state   <= S_MUL;
          end else begin
            tcnt <= TCNT_W'(tcnt + 1'b1);
          end
        end
        S_MUL: begin
          a_reg <= a_val;
          prod  <= 18'(a_val * prob);
          state <= S_CMP;
        end
        S_CMP: begin
          if (take_one) begin
            code_value  <= 8'(code_value - 8'(t_val + 9'd1));
            range_value <= 9'(a_reg - t_val);
            dec_bit     <= 1'b1;
            renorm_pending <= (9'(a_reg - t_val) < 9'd128);
          end else begin
            range_value <= 9'(t_val + 9'd1);
            dec_bit     <= 1'b0;
            renorm_pending <= (9'(t_val + 9'd1) < 9'd128);
          end
          tcnt  <= '0;
          state <= S_WR;
        end
        S_WR: begin
          prev_h <= h_old;
          if (tcnt == TCNT_W'(TAPS - 1)) begin
            row_valid[cur_ch] <= 1'b1;
            byte_accum <= {byte_accum[6:0], dec_bit};
            bit_pos    <= 3'(bit_pos + 3'd1);
            state      <= (bit_pos == 3'd7) ? S_EMIT : S_CHECK;
          end else begin
            tcnt <= TCNT_W'(tcnt + 1'b1);
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.decoded_byte  <= byte_accum;
            out_data.channel       <= cur_ch;
            out_data.last_in_frame <= last_byte;
            byte_accum             <= '0;
            if (last_byte) begin
              frame_idle     <= 1'b1;
              renorm_pending <= 1'b0;
            end else if (chan_wrap) begin
              chan_pos <= '0;
              byte_pos <= BPOS_W'(byte_pos + 1'b1);
            end else begin
              chan_pos <= CH_W'(cur_ch + 1'b1);
            end
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the emit step always loads the output register once it is free
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready)) |=> out_valid)
    else $error("byte not loaded into output register");

  // the code load never runs past eight bits
  assert property (@(posedge clk) disable iff (rst) load_count <= 4'd8)
    else $error("code load overran");

  // a decode pass only works on an existing channel row
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (cur_ch < CH_W'(MAX_CHANNELS)))
    else $error("channel out of range");

  // no decode starts while the frame is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && frame_idle) |=> (state == S_IDLE))
    else $error("decode while idle");

endmodule
